// File: sv/ramr_pkg.sv
// Package for the rational add/multiply/reduce core: item types and status codes.
// No dependencies.
`default_nettype none
package ramr_pkg;

  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = 31;
  localparam int unsigned WideW = 64;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_MUL = 1'b1;

  typedef struct packed {
    logic req_type;
    logic signed [NumW-1:0] a_num;
    logic [DenW-1:0] a_den;
    logic signed [NumW-1:0] b_num;
    logic [DenW-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [NumW-1:0] res_num;
    logic [DenW-1:0] res_den;
    logic [1:0] status;
  } out_item_t;

  // Request/response between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// File: sv/rational_add_mul_reduce_core.sv
// Rational add/multiply with gcd reduction: one item in, one result out.
// Latency is data dependent: each gcd step and each division runs in the shared
// 64-bit bit-serial divider, whose use varies with the operands (a zero product skips
// reduction, and a zero denominator skips all arithmetic).
// One item at a time, the next accepted once the result is taken; reset is synchronous,
// active low, and clears the sequencer. Depends on ramr_pkg, ramr_div, ramr_mul.
`default_nettype none
module rational_add_mul_reduce_core #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire ramr_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output ramr_pkg::out_item_t out_data
);
  localparam int unsigned W = ramr_pkg::WideW;
  localparam int unsigned N = ramr_pkg::NumW;
  localparam logic [W-1:0] Lim = W'(1) << (WIDTH - 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_GCD    = 4'd1;  // euclid on x_r,y_r
  localparam logic [3:0] S_GWAIT  = 4'd2;
  localparam logic [3:0] S_AD1    = 4'd3;  // bd/g
  localparam logic [3:0] S_AD2    = 4'd4;  // ad/g
  localparam logic [3:0] S_MUL1   = 4'd5;
  localparam logic [3:0] S_MUL2   = 4'd6;
  localparam logic [3:0] S_MUL3   = 4'd7;
  localparam logic [3:0] S_COMB   = 4'd8;
  localparam logic [3:0] S_RD1    = 4'd9;  // mag/g
  localparam logic [3:0] S_RD2    = 4'd10; // den/g
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_DWAIT  = 4'd12;

  logic [3:0] st_r, st_nxt, ret_r, ret_nxt;
  logic op_r, an_r, bn_r, neg_r, phase_r;
  logic op_nxt, an_nxt, bn_nxt, neg_nxt, phase_nxt;
  logic [N-1:0] am_r, bm_r, am_nxt, bm_nxt;
  logic [W-1:0] ad_r, bd_r, x_r, y_r, g_r, ta_r, tb_r, mag_r, den_r, t_r;
  logic [W-1:0] ad_nxt, bd_nxt, x_nxt, y_nxt, g_nxt, ta_nxt, tb_nxt, mag_nxt, den_nxt, t_nxt;
  logic out_valid_r, out_valid_nxt;
  ramr_pkg::out_item_t out_r, out_nxt;

  ramr_pkg::div_ctl_t dctl;
  ramr_pkg::div_sts_t dsts;
  logic [W-1:0] dvd, dvs, quot, rem;
  logic [N-1:0] ma, mb;
  logic [W-1:0] prod;

  ramr_div u_div (.clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
                  .sts(dsts), .quot(quot), .rem(rem));
  ramr_mul u_mul (.clk(clk), .op_a(ma), .op_b(mb), .prod(prod));

  function automatic logic [N-1:0] mag32(input logic [N-1:0] v);
    mag32 = v[N-1] ? (~v + 1'b1) : v;
  endfunction

  // Sequencer
  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; op_nxt = op_r; an_nxt = an_r; bn_nxt = bn_r;
    neg_nxt = neg_r; phase_nxt = phase_r; am_nxt = am_r; bm_nxt = bm_r;
    ad_nxt = ad_r; bd_nxt = bd_r; x_nxt = x_r; y_nxt = y_r; g_nxt = g_r;
    ta_nxt = ta_r; tb_nxt = tb_r; mag_nxt = mag_r; den_nxt = den_r; t_nxt = t_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;
    dctl.start = 1'b0; dvd = x_r; dvs = y_r;
    ma = am_r; mb = bm_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          op_nxt = in_data.req_type;
          an_nxt = in_data.a_num[N-1];
          bn_nxt = in_data.b_num[N-1];
          am_nxt = mag32(in_data.a_num);
          bm_nxt = mag32(in_data.b_num);
          ad_nxt = W'(in_data.a_den);
          bd_nxt = W'(in_data.b_den);
          if (in_data.a_den == '0 || in_data.b_den == '0) begin
            out_nxt = '{res_num: '0, res_den: '0, status: ramr_pkg::ST_ZERO_DEN};
            out_valid_nxt = 1'b1;
          end else if (in_data.req_type == ramr_pkg::REQ_ADD) begin
            x_nxt = W'(in_data.a_den);
            y_nxt = W'(in_data.b_den);
            ret_nxt = S_AD1;
            st_nxt = S_GCD;
          end else begin
            phase_nxt = 1'b0;
            st_nxt = S_MUL1;
          end
        end
      end
      S_GCD: begin
        if (y_r == '0) begin
          g_nxt = x_r;
          st_nxt = ret_r;
        end else begin
          dctl.start = 1'b1;
          st_nxt = S_GWAIT;
        end
      end
      S_GWAIT: begin
        if (dsts.done) begin
          x_nxt = y_r;
          y_nxt = rem;
          st_nxt = S_GCD;
        end
      end
      S_AD1: begin
        dvd = bd_r; dvs = g_r; dctl.start = 1'b1;
        ret_nxt = S_AD2; st_nxt = S_DWAIT; phase_nxt = 1'b0;
      end
      S_AD2: begin
        // t_r holds bd/g; now ad/g
        dvd = ad_r; dvs = g_r; dctl.start = 1'b1;
        ret_nxt = S_MUL1; st_nxt = S_DWAIT; phase_nxt = 1'b1;
      end
      S_DWAIT: begin
        if (dsts.done) begin
          t_nxt = quot;
          if (ret_r == S_AD2) tb_nxt = quot;       // bd/g kept in tb_r
          if (ret_r == S_MUL1) ta_nxt = quot;      // ad/g kept in ta_r
          if (ret_r == S_RD2) mag_nxt = quot;
          if (ret_r == S_OUT) den_nxt = quot;
          st_nxt = ret_r;
        end
      end
      S_MUL1: begin
        // add: t=(bd/g)*am ; mul: mag=am*bm
        if (op_r == ramr_pkg::REQ_ADD) begin
          ma = tb_r[N-1:0]; mb = am_r;
        end
        st_nxt = S_MUL2;
      end
      S_MUL2: begin
        if (op_r == ramr_pkg::REQ_ADD) begin
          t_nxt = prod;               // scaled a numerator
          ma = ta_r[N-1:0]; mb = bm_r;
        end else begin
          mag_nxt = prod;
          ma = ad_r[N-1:0]; mb = bd_r[N-1:0];
        end
        st_nxt = S_MUL3;
      end
      S_MUL3: begin
        if (op_r == ramr_pkg::REQ_ADD) begin
          tb_nxt = prod;              // scaled b numerator
          ma = ta_r[N-1:0]; mb = bd_r[N-1:0];
        end else begin
          den_nxt = prod;
          neg_nxt = an_r ^ bn_r;
        end
        st_nxt = S_COMB;
        phase_nxt = 1'b0;
      end
      S_COMB: begin
        if (op_r == ramr_pkg::REQ_ADD && !phase_r) begin
          // first pass combines the numerators; the den product is taken in the second pass
          ma = ta_r[N-1:0]; mb = bd_r[N-1:0];
          phase_nxt = 1'b1;
          if (an_r == bn_r) begin
            mag_nxt = t_r + tb_r; neg_nxt = an_r;
          end else if (t_r >= tb_r) begin
            mag_nxt = t_r - tb_r; neg_nxt = an_r;
          end else begin
            mag_nxt = tb_r - t_r; neg_nxt = bn_r;
          end
        end else begin
          if (op_r == ramr_pkg::REQ_ADD) den_nxt = prod;
          if (mag_r == '0 && !(op_r == ramr_pkg::REQ_ADD)) begin
            neg_nxt = 1'b0; den_nxt = W'(1); st_nxt = S_OUT;
          end else if (op_r == ramr_pkg::REQ_ADD && mag_r == '0) begin
            neg_nxt = 1'b0; den_nxt = W'(1); st_nxt = S_OUT;
          end else begin
            x_nxt = mag_r;
            y_nxt = (op_r == ramr_pkg::REQ_ADD) ? prod : den_r;
            ret_nxt = S_RD1;
            st_nxt = S_GCD;
          end
        end
      end
      S_RD1: begin
        dvd = mag_r; dvs = g_r; dctl.start = 1'b1;
        ret_nxt = S_RD2; st_nxt = S_DWAIT;
      end
      S_RD2: begin
        dvd = den_r; dvs = g_r; dctl.start = 1'b1;
        ret_nxt = S_OUT; st_nxt = S_DWAIT;
      end
      S_OUT: begin
        if ((neg_r ? (mag_r > Lim) : (mag_r >= Lim)) || den_r >= Lim) begin
          out_nxt = '{res_num: '0, res_den: '0, status: ramr_pkg::ST_OVERFLOW};
        end else begin
          out_nxt.res_num = neg_r ? (~mag_r[N-1:0] + 1'b1) : mag_r[N-1:0];
          out_nxt.res_den = den_r[ramr_pkg::DenW-1:0];
          out_nxt.status = ramr_pkg::ST_OK;
        end
        out_valid_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ret_r <= ret_nxt; op_r <= op_nxt; an_r <= an_nxt; bn_r <= bn_nxt;
    neg_r <= neg_nxt; phase_r <= phase_nxt; am_r <= am_nxt; bm_r <= bm_nxt;
    ad_r <= ad_nxt; bd_r <= bd_nxt; x_r <= x_nxt; y_r <= y_nxt; g_r <= g_nxt;
    ta_r <= ta_nxt; tb_r <= tb_nxt; mag_r <= mag_nxt; den_r <= den_nxt; t_r <= t_nxt;
    out_r <= out_nxt;
  end

  assign in_ready = (st_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // Result never changes while waiting to be taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("result changed while stalled");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_ready) else $error("ready while working");
  a_ok_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == ramr_pkg::ST_OK |-> out_r.res_den != '0)
    else $error("ok result with zero denominator");
endmodule
`default_nettype wire

// File: sv/ramr_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit unsigned operands.
// Depends on ramr_pkg.
`default_nettype none
module ramr_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire ramr_pkg::div_ctl_t ctl,
  input  wire logic [ramr_pkg::WideW-1:0] dividend,
  input  wire logic [ramr_pkg::WideW-1:0] divisor,
  output ramr_pkg::div_sts_t sts,
  output logic [ramr_pkg::WideW-1:0] quot,
  output logic [ramr_pkg::WideW-1:0] rem
);
  localparam int unsigned W = ramr_pkg::WideW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0] trial;

  // One shift-subtract step per cycle
  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {r_r, q_r[W-1]} - {1'b0, d_r};
    if (ctl.start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = CntW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[W]) begin
        r_nxt = {r_r[W-2:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot = q_r;
  assign rem = r_r;

  // Done only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> $past(busy_r)) else $error("divider done without busy");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r)) else $error("divider busy and done together");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0 || $past(ctl.start) == 1'b0)
    else $error("divider count inconsistent");
endmodule
`default_nettype wire

// File: sv/ramr_mul.sv
// Registered 32x32 unsigned multiplier.
// Depends on ramr_pkg.
`default_nettype none
module ramr_mul (
  input  wire logic clk,
  input  wire logic [ramr_pkg::NumW-1:0] op_a,
  input  wire logic [ramr_pkg::NumW-1:0] op_b,
  output logic [ramr_pkg::WideW-1:0] prod
);
  logic [ramr_pkg::WideW-1:0] prod_r;
  // Product register
  always_ff @(posedge clk) begin
    prod_r <= ramr_pkg::WideW'(op_a) * ramr_pkg::WideW'(op_b);
  end
  assign prod = prod_r;
endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench for rational_add_mul_reduce_core: random and directed fraction items,
// results checked against an in-bench rational predictor. Depends on ramr_pkg and rational_add_mul_reduce_core.
`default_nettype none
module tb;

  localparam int unsigned WIDTH = 32;
  localparam longint unsigned CYCLE_LIMIT = 64'd100000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ramr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ramr_pkg::out_item_t out_data;

  ramr_pkg::in_item_t pending_q[$];
  ramr_pkg::out_item_t expected_q[$];
  int unsigned err_count = 0;
  longint unsigned cycle_cnt = 0;
  bit stim_done = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  rational_add_mul_reduce_core #(.WIDTH(WIDTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Expected result of one fraction item
  function automatic ramr_pkg::out_item_t reduce_fraction(ramr_pkg::in_item_t it);
    ramr_pkg::out_item_t o;
    logic [63:0] am, bm, ad, bd, mag, den, g, ta, tb, lim;
    logic an, bn, neg;
    o = '0;
    an = it.a_num[31];
    bn = it.b_num[31];
    am = an ? 64'(-$signed({32'hffffffff, it.a_num})) : 64'(it.a_num);
    bm = bn ? 64'(-$signed({32'hffffffff, it.b_num})) : 64'(it.b_num);
    ad = 64'(it.a_den);
    bd = 64'(it.b_den);
    if (ad == 0 || bd == 0) begin
      o.status = ramr_pkg::ST_ZERO_DEN;
      return o;
    end
    if (it.req_type == ramr_pkg::REQ_ADD) begin
      g = gcd64(ad, bd);
      ta = (bd / g) * am;
      tb = (ad / g) * bm;
      den = (ad / g) * bd;
      if (an == bn) begin
        mag = ta + tb;
        neg = an;
      end else if (ta >= tb) begin
        mag = ta - tb;
        neg = an;
      end else begin
        mag = tb - ta;
        neg = bn;
      end
    end else begin
      mag = am * bm;
      den = ad * bd;
      neg = an ^ bn;
    end
    if (mag == 0) begin
      neg = 1'b0;
      den = 64'd1;
    end else begin
      g = gcd64(mag, den);
      mag = mag / g;
      den = den / g;
    end
    lim = 64'd1 << (WIDTH - 1);
    if ((neg ? (mag > lim) : (mag >= lim)) || den >= lim) begin
      o.status = ramr_pkg::ST_OVERFLOW;
      return o;
    end
    o.res_num = neg ? 32'(-mag) : 32'(mag);
    o.res_den = 31'(den);
    o.status = ramr_pkg::ST_OK;
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_cnt);
    err_count++;
  endtask

  function automatic logic [31:0] rand_num(int unsigned mode);
    case (mode)
      0: return 32'($urandom_range(0, 20)) - 32'd10;
      1: return 32'($urandom_range(0, 2000)) - 32'd1000;
      2: return 32'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_den(int unsigned mode);
    case (mode)
      0: return 31'($urandom_range(1, 12));
      1: return 31'($urandom_range(1, 1000));
      2: return 31'($urandom_range(1, 65536));
      default: return 31'($urandom_range(1, 32'h7fffffff));
    endcase
  endfunction

  function automatic ramr_pkg::in_item_t make_item(logic op, logic [31:0] an, logic [30:0] ad,
                                                   logic [31:0] bn, logic [30:0] bd);
    ramr_pkg::in_item_t it;
    it.req_type = op;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  // Stimulus: directed corners then random items
  initial begin
    ramr_pkg::in_item_t it;
    int unsigned m;
    for (int op = 0; op < 2; op++) begin
      pending_q.push_back(make_item(1'(op), 32'h7fffffff, 31'd1, 32'h7fffffff, 31'd1));
      pending_q.push_back(make_item(1'(op), 32'h80000000, 31'd1, 32'h80000000, 31'd1));
      pending_q.push_back(make_item(1'(op), 32'h80000000, 31'h7fffffff, 32'd1,
                                    31'h7fffffff));
      pending_q.push_back(make_item(1'(op), 32'd0, 31'd5, 32'd7, 31'd3));
      pending_q.push_back(make_item(1'(op), 32'd3, 31'd0, 32'd7, 31'd3));
      pending_q.push_back(make_item(1'(op), 32'd3, 31'd4, 32'd7, 31'd0));
      pending_q.push_back(make_item(1'(op), 32'd1, 31'd2, 32'hffffffff, 31'd2));
      pending_q.push_back(make_item(1'(op), 32'h80000000, 31'd1, 32'hffffffff, 31'd1));
      pending_q.push_back(make_item(1'(op), 32'd6, 31'd4, 32'd10, 31'd15));
      pending_q.push_back(make_item(1'(op), 32'hffffffff, 31'h7fffffff, 32'h7fffffff,
                                    31'h7ffffffe));
      pending_q.push_back(make_item(1'(op), 32'h40000000, 31'd3, 32'h40000000, 31'd3));
    end
    for (int i = 0; i < 1650; i++) begin
      m = $urandom_range(0, 3);
      it = make_item(1'($urandom_range(0, 1)), rand_num(m), rand_den(m),
                     rand_num($urandom_range(0, 3)), rand_den($urandom_range(0, 3)));
      // occasional zero denominator
      if ($urandom_range(0, 40) == 0) it.a_den = '0;
      if ($urandom_range(0, 40) == 0) it.b_den = '0;
      pending_q.push_back(it);
    end
    stim_done = 1'b1;
  end

  // Reset and run control
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && pending_q.size() == 0 && !in_valid && expected_q.size() == 0))
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(reduce_fraction(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: own stall pattern plus one long hold-off while a result waits
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && out_valid && cycle_cnt > 5000) begin
      hold_done <= 1'b1;
      hold_left <= 20000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ((cycle_cnt / 3000) % 4 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    ramr_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(out_data), 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.res_num !== want.res_num)
          report("res_num", 64'(out_data.res_num), 64'(want.res_num));
        if (out_data.res_den !== want.res_den)
          report("res_den", 64'(out_data.res_den), 64'(want.res_den));
        if (out_data.status !== want.status)
          report("status", 64'(out_data.status), 64'(want.status));
      end
    end
  end
endmodule
`default_nettype wire

// File: filelist.f
sv/ramr_pkg.sv
sv/ramr_div.sv
sv/ramr_mul.sv
sv/rational_add_mul_reduce_core.sv
sim/tb.sv
